// File: hdl/uitfp_pkg.sv
// ----------------------------------------------------------------------------
// uitfp_pkg
// Shared types and constants of the UART idle-timeout frame parser: reply
// kinds, frame word characters, and the command and status groups between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package uitfp_pkg;

	// reply kinds
	localparam logic [1:0] KIND_OK    = 2'd0;
	localparam logic [1:0] KIND_ERROR = 2'd1;
	localparam logic [1:0] KIND_DATA  = 2'd2;

	// request types
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// characters
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;

	// length of the "+NNMI" header and of the "OK" and "ERROR" words
	localparam int HDR_LEN   = 5;
	localparam int OK_LEN    = 2;
	localparam int ERROR_LEN = 5;

	// idle timeout after reset
	localparam logic [7:0] TIMEOUT_RESET = 8'd10;

	// controller to datapath
	typedef struct packed {
		logic accept;  // take the input word
		logic start;   // open a scan of the closed frame
		logic read;    // read the next stored byte
		logic eval;    // consume the byte just read
		logic finish;  // emit the ok or error reply
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic close;      // the offered word is a tick that closes the frame
		logic scan_done;  // every stored byte has been consumed
		logic pair_out;   // the byte just read completes a data pair
		logic out_free;   // the output register can take a word
		logic has_reply;  // the frame matched "OK" or "ERROR"
	} sts_t;

	function automatic logic [7:0] ok_char(input logic idx);
		return idx ? 8'h4B : 8'h4F;
	endfunction

	function automatic logic [7:0] error_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h45;
			3'd1:    c = 8'h52;
			3'd2:    c = 8'h52;
			3'd3:    c = 8'h4F;
			default: c = 8'h52;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] nnmi_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h2B;
			3'd1:    c = 8'h4E;
			3'd2:    c = 8'h4E;
			3'd3:    c = 8'h4D;
			default: c = 8'h49;
		endcase
		return c;
	endfunction

endpackage

// File: hdl/uitfp_if.sv
// ----------------------------------------------------------------------------
// uitfp_if
// Valid/ready channels of the frame parser: the request channel carries
// received bytes and timer ticks, the reply channel carries parsed results.
// ----------------------------------------------------------------------------
interface uitfp_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] rx_byte;

	modport source (output valid, req_type, rx_byte, input ready);
	modport sink   (input valid, req_type, rx_byte, output ready);
endinterface

interface uitfp_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] reply_kind;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, reply_kind, data_byte, last, input ready);
	modport sink   (input valid, reply_kind, data_byte, last, output ready);
endinterface

// File: hdl/uitfp_ctrl.sv
// ----------------------------------------------------------------------------
// uitfp_ctrl
// Controller of the frame parser: takes request words while idle and walks
// the closed frame one stored byte at a time, pacing the reply output.
// ----------------------------------------------------------------------------
module uitfp_ctrl
	import uitfp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_EVAL = 2'd2;
	localparam logic [1:0] ST_END  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					if (sts.close) begin
						cmd.start = 1'b1;
						state_d   = ST_READ;
					end
				end
			end
			ST_READ: begin
				if (sts.scan_done) begin
					state_d = ST_END;
				end else begin
					cmd.read = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				// hold while a data word waits for room at the output
				if (!sts.pair_out || sts.out_free) begin
					cmd.eval = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_END: begin
				if (!sts.has_reply) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hdl/uitfp_dp.sv
// ----------------------------------------------------------------------------
// uitfp_dp
// Datapath of the frame parser: frame store, length and idle counting,
// timeout register, frame classification flags, pair decoder and the
// reply output register.
// ----------------------------------------------------------------------------
module uitfp_dp
	import uitfp_pkg::*;
#(
	parameter int FRAME_BYTES = 64,
	parameter int FRAME_SLOTS = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       req_type,
	input  logic [7:0] rx_byte,
	input  cmd_t       cmd,
	output sts_t       sts,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] reply_kind,
	output logic [7:0] data_byte,
	output logic       last
);

	localparam int LEN_W  = $clog2(FRAME_BYTES);
	localparam int SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
	localparam int DEPTH  = FRAME_SLOTS * FRAME_BYTES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(FRAME_BYTES - 1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FRAME_SLOTS - 1);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_q;

	logic [7:0]        timeout_q;
	logic              receiving_q;
	logic [7:0]        idle_q;
	logic [SLOT_W-1:0] wslot_q;
	logic [SLOT_W-1:0] sslot_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  idx_q;
	logic              ok_q, err_q, nn_q, comma_q, phase_q;
	logic [7:0]        hi_q;

	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [7:0]        data_q;
	logic              last_q;

	logic [7:0]        idle_inc;
	logic [LEN_W-1:0]  wr_len;
	logic              is_byte, is_tick;
	logic              mem_we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [7:0]        hi_off, lo_off, pair_val;
	logic              pair_last;
	logic              idx_hdr, idx_ok, out_free;

	assign is_byte  = cmd.accept && (req_type == REQ_BYTE);
	assign is_tick  = cmd.accept && (req_type == REQ_TICK);
	assign idle_inc = (idle_q == 8'hFF) ? idle_q : idle_q + 8'd1;
	assign wr_len   = receiving_q ? len_q : '0;
	assign mem_we   = is_byte && (wr_len < LEN_MAX);
	assign waddr    = ADDR_W'(int'(wslot_q) * FRAME_BYTES + int'(wr_len));
	assign raddr    = ADDR_W'(int'(sslot_q) * FRAME_BYTES + int'(idx_q));

	// decode one pair of characters
	assign hi_off    = hi_q - CHAR_ZERO;
	assign lo_off    = rd_q - CHAR_ZERO;
	assign pair_val  = {hi_off[3:0], 4'b0000} + lo_off;
	assign pair_last = ({1'b0, idx_q} + (LEN_W+1)'(2)) >= {1'b0, len_q};

	assign idx_hdr  = idx_q < LEN_W'(HDR_LEN);
	assign idx_ok   = idx_q < LEN_W'(OK_LEN);
	assign out_free = !out_valid_q || out_ready;

	// status towards the controller
	always_comb begin
		sts.close     = (req_type == REQ_TICK) && receiving_q && (idle_inc >= timeout_q);
		sts.scan_done = idx_q == len_q;
		sts.pair_out  = nn_q && comma_q && phase_q;
		sts.out_free  = out_free;
		sts.has_reply = ok_q || err_q;
	end

	// frame store: one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= rx_byte;
		end
		if (cmd.read) begin
			rd_q <= mem[raddr];
		end
	end

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// frame reception: length, idle count, slot swap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			idle_q      <= '0;
			wslot_q     <= '0;
			len_q       <= '0;
		end else if (is_byte) begin
			receiving_q <= 1'b1;
			idle_q      <= '0;
			len_q       <= mem_we ? wr_len + 1'b1 : wr_len;
		end else if (is_tick && receiving_q) begin
			idle_q <= idle_inc;
			if (sts.close) begin
				receiving_q <= 1'b0;
				wslot_q     <= (wslot_q == SLOT_LAST) ? '0 : wslot_q + 1'b1;
			end
		end
	end

	// scan of the closed frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sslot_q <= '0;
			idx_q   <= '0;
			ok_q    <= 1'b0;
			err_q   <= 1'b0;
			nn_q    <= 1'b0;
			comma_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (cmd.start) begin
			sslot_q <= wslot_q;
			idx_q   <= '0;
			ok_q    <= 1'b1;
			err_q   <= 1'b1;
			nn_q    <= 1'b1;
			comma_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (cmd.eval) begin
			idx_q <= idx_q + 1'b1;
			ok_q  <= ok_q && idx_ok && (rd_q == ok_char(idx_q[0]));
			err_q <= err_q && idx_hdr && (rd_q == error_char(idx_q[2:0]));
			if (idx_hdr) begin
				nn_q <= nn_q && (rd_q == nnmi_char(idx_q[2:0]));
			end
			if (!idx_hdr && !comma_q) begin
				comma_q <= rd_q == CHAR_COMMA;
			end else if (comma_q) begin
				phase_q <= !phase_q;
			end
		end
	end

	// first character of a pair
	always_ff @(posedge clk) begin
		if (cmd.eval && comma_q && !phase_q) begin
			hi_q <= rd_q;
		end
	end

	// reply output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.eval && sts.pair_out) || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval && sts.pair_out) begin
			kind_q <= KIND_DATA;
			data_q <= pair_val;
			last_q <= pair_last;
		end else if (cmd.finish) begin
			kind_q <= ok_q ? KIND_OK : KIND_ERROR;
			data_q <= '0;
			last_q <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign reply_kind = kind_q;
	assign data_byte  = data_q;
	assign last       = last_q;

endmodule

// File: hdl/uart_idle_timeout_frame_parser_top.sv
// A byte or a tick that does not close the frame leaves the parser idle. A
// closing tick walks the stored frame one byte at a time, and each reply word
// leaves through a register; a full stall at the output halts the walk. One
// word is worked on at a time. Reset clears control state and sets the idle
// timeout to 10 ticks; the frame store is not cleared.
// ----------------------------------------------------------------------------
// uart_idle_timeout_frame_parser_top
// Top level: collects UART bytes into ping-pong frame slots, closes a frame
// after an idle timeout and replies with ok, error or decoded data words.
// ----------------------------------------------------------------------------
module uart_idle_timeout_frame_parser_top
	import uitfp_pkg::*;
#(
	parameter int FRAME_BYTES = 64,
	parameter int FRAME_SLOTS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	uitfp_in_if.sink    req,
	uitfp_out_if.source rsp
);

	cmd_t cmd;
	sts_t sts;

	// sequence the work
	uitfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// store and parse
	uitfp_dp #(
		.FRAME_BYTES (FRAME_BYTES),
		.FRAME_SLOTS (FRAME_SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_type   (req.req_type),
		.rx_byte    (req.rx_byte),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.reply_kind (rsp.reply_kind),
		.data_byte  (rsp.data_byte),
		.last       (rsp.last)
	);

endmodule
